### rtl/core/sss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sss_pkg - Staircase swipe sequencer package
// Shared types, register indexes, command codes and reset values.
// ============================================================================
package sss_pkg;

    // Field widths.
    localparam int unsigned MASK_W   = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned WIN_W    = 6;
    localparam int unsigned FIRST_W  = 5;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned AGE_W    = 32;
    localparam int unsigned WAIT_W   = 8;

    // Ticks between a command and the swipe preset, and between the end of
    // an off swipe and the solid preset.
    localparam logic [WAIT_W-1:0] PRESET_WAIT = 8'd250;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] CFG_STEP_DELAY    = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_HOLD_TIME     = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_FIRST_SEGMENT = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_END_SEGMENT   = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_BLOCK_ENABLE  = 3'd4;

    // Swipe command codes; other codes are unrecognized.
    localparam logic [CMD_W-1:0] CMD_ON_UP    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ON_DOWN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OFF_UP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OFF_DOWN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NONE     = 3'd4;

    // Configuration register reset values.
    localparam logic [DELAY_W-1:0] STEP_DELAY_RST    = 16'd150;
    localparam logic [AGE_W-1:0]   HOLD_TIME_RST     = 32'd30000;
    localparam logic [FIRST_W-1:0] FIRST_SEGMENT_RST = 5'd0;
    localparam logic [WIN_W-1:0]   END_SEGMENT_RST   = 6'd1;

    typedef struct packed {
        logic [DELAY_W-1:0] step_delay;
        logic [AGE_W-1:0]   hold_time;
        logic [FIRST_W-1:0] first_segment;
        logic [WIN_W-1:0]   end_segment;
        logic               block_enable;
    } t_cfg;

    typedef struct packed {
        logic               lit;
        logic               swiping;
        logic               auto_off;
        logic               dir_up;
        logic               last_from_top;
        logic [WIN_W-1:0]   win_lo;
        logic [WIN_W-1:0]   win_hi;
        logic [AGE_W-1:0]   step_age;
        logic [AGE_W-1:0]   switch_age;
        logic               swipe_pend;
        logic [WAIT_W-1:0]  swipe_wait;
        logic [CMD_W-1:0]   pend_cmd;
        logic               solid_pend;
        logic [WAIT_W-1:0]  solid_wait;
    } t_state;

    // Per-beat event flags produced by the step logic.
    typedef struct packed {
        logic mask_update;
        logic apply_black;
        logic apply_swipe;
        logic apply_solid;
    } t_flags;

    typedef struct packed {
        logic [MASK_W-1:0] segment_mask;
        t_flags            flags;
        logic              lights_on;
        logic              animating;
    } t_result;

    // Window reset: low at the first segment, high at end segment minus one.
    localparam t_state STATE_RST = '{
        lit:           1'b0,
        swiping:       1'b0,
        auto_off:      1'b0,
        dir_up:        1'b1,
        last_from_top: 1'b0,
        win_lo:        6'd0,
        win_hi:        6'd0,
        step_age:      32'd0,
        switch_age:    32'd0,
        swipe_pend:    1'b0,
        swipe_wait:    8'd0,
        pend_cmd:      CMD_NONE,
        solid_pend:    1'b0,
        solid_wait:    8'd0
    };

endpackage
`default_nettype wire

### rtl/core/sss_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sss_if - Staircase swipe sequencer stream interfaces
// Valid/ready channels for request beats and result beats.
// ============================================================================

// Request channel: a tick or a swipe command.
interface sss_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [sss_pkg::CMD_W-1:0] command;

    modport source (output valid, output req_type, output command, input ready);
    modport sink   (input valid, input req_type, input command, output ready);
endinterface

// Result channel: one beat per request beat.
interface sss_res_if;
    logic                       valid;
    logic                       ready;
    logic [sss_pkg::MASK_W-1:0] segment_mask;
    logic                       mask_update;
    logic                       apply_black;
    logic                       apply_swipe;
    logic                       apply_solid;
    logic                       lights_on;
    logic                       animating;

    modport source (
        output valid, output segment_mask, output mask_update, output apply_black,
        output apply_swipe, output apply_solid, output lights_on, output animating,
        input ready
    );
    modport sink (
        input valid, input segment_mask, input mask_update, input apply_black,
        input apply_swipe, input apply_solid, input lights_on, input animating,
        output ready
    );
endinterface
`default_nettype wire

### rtl/core/sss_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sss_cfg_regs - Configuration registers
// Write-only register file holding delays, segment bounds and enable.
// ============================================================================
module sss_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [sss_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [sss_pkg::DATA_W-1:0]  i_cfg_wdata,
    output sss_pkg::t_cfg                    o_cfg
);

    sss_pkg::t_cfg r_cfg;

    // Each register takes the low bits of the write data; other indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_delay    <= sss_pkg::STEP_DELAY_RST;
            r_cfg.hold_time     <= sss_pkg::HOLD_TIME_RST;
            r_cfg.first_segment <= sss_pkg::FIRST_SEGMENT_RST;
            r_cfg.end_segment   <= sss_pkg::END_SEGMENT_RST;
            r_cfg.block_enable  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sss_pkg::CFG_STEP_DELAY: begin
                    r_cfg.step_delay <= i_cfg_wdata[sss_pkg::DELAY_W-1:0];
                end
                sss_pkg::CFG_HOLD_TIME: begin
                    r_cfg.hold_time <= i_cfg_wdata[sss_pkg::AGE_W-1:0];
                end
                sss_pkg::CFG_FIRST_SEGMENT: begin
                    r_cfg.first_segment <= i_cfg_wdata[sss_pkg::FIRST_W-1:0];
                end
                sss_pkg::CFG_END_SEGMENT: begin
                    r_cfg.end_segment <= i_cfg_wdata[sss_pkg::WIN_W-1:0];
                end
                sss_pkg::CFG_BLOCK_ENABLE: begin
                    r_cfg.block_enable <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### rtl/core/sss_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sss_step - Sequencer next-state logic
// Applies one tick or command beat to the sequencer state and raises the
// preset and mask update flags for that beat.
// ============================================================================
module sss_step (
    input  wire sss_pkg::t_cfg              i_cfg,
    input  wire sss_pkg::t_state            i_state,
    input  wire logic                       i_req_type,
    input  wire logic [sss_pkg::CMD_W-1:0]  i_command,
    output sss_pkg::t_state                 o_state,
    output sss_pkg::t_flags                 o_flags
);

    sss_pkg::t_state            s;
    sss_pkg::t_flags            f;
    logic [sss_pkg::WIN_W-1:0]  first6;
    logic [sss_pkg::WIN_W-1:0]  low_dec;
    logic [sss_pkg::WIN_W:0]    high_inc;
    logic                       full;

    assign first6 = {1'b0, i_cfg.first_segment};

    always_comb begin
        s        = i_state;
        f        = '0;
        low_dec  = '0;
        high_inc = '0;
        full     = 1'b0;

        if (i_req_type) begin
            // Command beat: latch it, flag black, restart the swipe wait.
            s.pend_cmd    = i_command;
            f.apply_black = 1'b1;
            s.swipe_pend  = 1'b1;
            s.swipe_wait  = '0;
        end else begin
            // Tick beat: saturating ages and armed wait counters.
            if (s.step_age != '1) begin
                s.step_age = s.step_age + 32'd1;
            end
            if (s.switch_age != '1) begin
                s.switch_age = s.switch_age + 32'd1;
            end
            if (s.swipe_pend && s.swipe_wait != '1) begin
                s.swipe_wait = s.swipe_wait + 8'd1;
            end
            if (s.solid_pend && s.solid_wait != '1) begin
                s.solid_wait = s.solid_wait + 8'd1;
            end

            // Solid preset, only when the staircase is dark and still.
            if (s.solid_pend && s.solid_wait >= sss_pkg::PRESET_WAIT) begin
                if (!s.swiping && !s.lit) begin
                    f.apply_solid = 1'b1;
                end
                s.solid_pend = 1'b0;
            end

            // Swipe preset: load the window and start the swipe unless an on
            // swipe is already running.
            if (s.swipe_pend && s.swipe_wait >= sss_pkg::PRESET_WAIT) begin
                s.swipe_pend  = 1'b0;
                f.apply_swipe = 1'b1;
                case (s.pend_cmd)
                    sss_pkg::CMD_ON_UP: begin
                        s.win_lo = i_cfg.end_segment - 6'd1;
                        s.win_hi = i_cfg.end_segment;
                        if (!s.swiping || !s.lit) begin
                            s.dir_up        = 1'b1;
                            s.last_from_top = 1'b1;
                            s.lit           = 1'b1;
                            s.swiping       = 1'b1;
                            s.auto_off      = 1'b0;
                        end
                    end
                    sss_pkg::CMD_ON_DOWN: begin
                        s.win_lo = first6;
                        s.win_hi = first6 + 6'd1;
                        if (!s.swiping || !s.lit) begin
                            s.dir_up        = 1'b0;
                            s.last_from_top = 1'b0;
                            s.lit           = 1'b1;
                            s.swiping       = 1'b1;
                            s.auto_off      = 1'b0;
                        end
                    end
                    sss_pkg::CMD_OFF_UP, sss_pkg::CMD_OFF_DOWN: begin
                        s.win_lo = first6;
                        s.win_hi = i_cfg.end_segment;
                        if (!s.swiping || !s.lit) begin
                            s.dir_up  = (s.pend_cmd == sss_pkg::CMD_OFF_UP);
                            s.lit     = 1'b0;
                            s.swiping = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!i_state.swiping || !i_state.lit) begin
                    s.switch_age = '0;
                    s.step_age   = '0;
                end
            end

            if (i_cfg.block_enable) begin
                // Automatic off after the hold time, opposite to the on swipe.
                if (s.lit && !s.swiping && !s.auto_off && s.switch_age > i_cfg.hold_time) begin
                    s.lit      = 1'b0;
                    s.swiping  = 1'b1;
                    s.auto_off = 1'b1;
                    s.step_age = '0;
                    s.dir_up   = !s.last_from_top;
                    s.win_lo   = first6;
                    s.win_hi   = i_cfg.end_segment;
                end

                // One segment step once the step delay has passed.
                if (s.swiping && s.step_age > {16'd0, i_cfg.step_delay}) begin
                    s.step_age    = '0;
                    f.mask_update = 1'b1;
                    if (s.lit) begin
                        if (s.dir_up) begin
                            low_dec = (s.win_lo != '0) ? s.win_lo - 6'd1 : '0;
                            s.win_lo = (s.win_lo == '0 || low_dec < first6) ? first6 : low_dec;
                            full = (s.win_lo == first6);
                        end else begin
                            high_inc = {1'b0, s.win_hi} + 7'd1;
                            s.win_hi = (high_inc < {1'b0, i_cfg.end_segment}) ?
                                       high_inc[sss_pkg::WIN_W-1:0] : i_cfg.end_segment;
                            full = (s.win_hi == i_cfg.end_segment);
                        end
                        if (full) begin
                            s.swiping = 1'b0;
                        end
                    end else begin
                        if (s.dir_up) begin
                            if (s.win_lo < s.win_hi) begin
                                s.win_lo = s.win_lo + 6'd1;
                            end
                            full = (s.win_lo >= s.win_hi);
                        end else begin
                            if (s.win_hi > s.win_lo) begin
                                s.win_hi = s.win_hi - 6'd1;
                            end
                            full = (s.win_hi <= s.win_lo);
                        end
                        // Off swipe done: black now, solid after the wait.
                        if (full) begin
                            s.swiping     = 1'b0;
                            s.auto_off    = 1'b0;
                            s.win_lo      = i_cfg.end_segment;
                            s.win_hi      = first6;
                            f.apply_black = 1'b1;
                            s.solid_pend  = 1'b1;
                            s.solid_wait  = '0;
                        end
                    end
                end
            end
        end
    end

    assign o_state = s;
    assign o_flags = f;

endmodule
`default_nettype wire

### rtl/core/sss_mask.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sss_mask - Lit segment mask
// Sets bit i when segment i lies inside both the lit window and the
// configured segment range.
// ============================================================================
module sss_mask #(
    parameter int unsigned SEGMENTS = 32
) (
    input  wire logic [sss_pkg::WIN_W-1:0]   i_win_lo,
    input  wire logic [sss_pkg::WIN_W-1:0]   i_win_hi,
    input  wire logic [sss_pkg::FIRST_W-1:0] i_first_segment,
    input  wire logic [sss_pkg::WIN_W-1:0]   i_end_segment,
    output logic [sss_pkg::MASK_W-1:0]       o_mask
);

    logic open_window;

    // An empty or inverted window lights nothing.
    assign open_window = (i_win_lo < i_win_hi);

    for (genvar i = 0; i < sss_pkg::MASK_W; i++) begin : g_bit
        localparam logic [sss_pkg::WIN_W-1:0] IDX = sss_pkg::WIN_W'(i);
        if (i < SEGMENTS) begin : g_live
            assign o_mask[i] = open_window
                             && (IDX >= {1'b0, i_first_segment}) && (IDX < i_end_segment)
                             && (IDX >= i_win_lo) && (IDX < i_win_hi);
        end else begin : g_dead
            assign o_mask[i] = 1'b0;
        end
    end

endmodule
`default_nettype wire

### rtl/core/staircase_swipe_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// staircase_swipe_sequencer - Staircase swipe sequencer top level
// Turns tick and swipe command beats into lit segment masks and preset
// requests, one result beat per request beat.
// ============================================================================
//
//  Channel   Dir   Handshake          Payload
//  i_req     in    valid / ready      req_type, command
//  o_res     out   valid / ready      segment_mask, mask_update, apply_black,
//                                     apply_swipe, apply_solid, lights_on,
//                                     animating
//  cfg       in    i_cfg_we           i_cfg_addr, i_cfg_wdata
//
//  A request beat is held in the input register while the step logic works
//  on it; the state and the result register load when the beat moves on,
//  so each result is offered from the result register, and one beat is
//  taken every cycle while the result channel is not stalled.
//  Synchronous active-low reset clears state and configuration to defaults.
//  A stalled result holds in the output register; the input register can
//  still take one beat and then holds it as well.
// ============================================================================
module staircase_swipe_sequencer #(
    parameter int unsigned SEGMENTS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    sss_req_if.sink                          i_req,
    sss_res_if.source                        o_res,
    input  wire logic                        i_cfg_we,
    input  wire logic [sss_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [sss_pkg::DATA_W-1:0]  i_cfg_wdata
);

    sss_pkg::t_cfg                  cfg;
    sss_pkg::t_state                r_state;
    sss_pkg::t_state                n_state;
    sss_pkg::t_flags                n_flags;
    sss_pkg::t_result               r_out;
    logic [sss_pkg::MASK_W-1:0]     n_mask;
    logic                           r_in_valid;
    logic                           r_in_req_type;
    logic [sss_pkg::CMD_W-1:0]      r_in_command;
    logic                           r_out_valid;
    logic                           move;
    logic                           in_accept;

    sss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Handshake: the held beat moves on when the result register frees up.
    assign move        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || move;
    assign in_accept   = i_req.valid && i_req.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_req_type <= i_req.req_type;
            r_in_command  <= i_req.command;
        end
    end

    sss_step u_step (
        .i_cfg      (cfg),
        .i_state    (r_state),
        .i_req_type (r_in_req_type),
        .i_command  (r_in_command),
        .o_state    (n_state),
        .o_flags    (n_flags)
    );

    sss_mask #(
        .SEGMENTS (SEGMENTS)
    ) u_mask (
        .i_win_lo        (n_state.win_lo),
        .i_win_hi        (n_state.win_hi),
        .i_first_segment (cfg.first_segment),
        .i_end_segment   (cfg.end_segment),
        .o_mask          (n_mask)
    );

    // Sequencer state advances once per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sss_pkg::STATE_RST;
        end else if (move) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out.segment_mask <= n_mask;
            r_out.flags        <= n_flags;
            r_out.lights_on    <= n_state.lit;
            r_out.animating    <= n_state.swiping;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.segment_mask = r_out.segment_mask;
    assign o_res.mask_update  = r_out.flags.mask_update;
    assign o_res.apply_black  = r_out.flags.apply_black;
    assign o_res.apply_swipe  = r_out.flags.apply_swipe;
    assign o_res.apply_solid  = r_out.flags.apply_solid;
    assign o_res.lights_on    = r_out.lights_on;
    assign o_res.animating    = r_out.animating;

`ifndef ASSERT_OFF
    // An automatic off swipe only runs with the lights switched off.
    a_auto_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.auto_off |-> !r_state.lit)
        else $error("auto off running while lit");

    // A new result only appears after a beat left the input register.
    a_result_from_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(move))
        else $error("result without a moved beat");

    // A held beat that cannot move stays in the input register unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !move) |=> (r_in_valid && $stable(r_in_command)
                                   && $stable(r_in_req_type)))
        else $error("held request beat lost");
`endif

endmodule
`default_nettype wire
